// ===== design/vfm_pkg.sv =====
// vfm_pkg: shared types, codes and face/corner tables of the voxel face mesher
`default_nettype none

package vfm_pkg;

   // chunk edge default and field widths
   localparam int CHUNK_EDGE_DEFAULT = 16;
   localparam int COORD_W  = 4;
   localparam int VERT_W   = 5;
   localparam int BTYPE_W  = 3;
   localparam int MAP_W    = 27;
   localparam int INDEX_W  = 17;
   localparam int FACES    = 6;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // face codes in emission order
   localparam logic [2:0] FACE_TOP    = 3'd0;
   localparam logic [2:0] FACE_BOTTOM = 3'd1;
   localparam logic [2:0] FACE_LEFT   = 3'd2;
   localparam logic [2:0] FACE_RIGHT  = 3'd3;
   localparam logic [2:0] FACE_FRONT  = 3'd4;
   localparam logic [2:0] FACE_BACK   = 3'd5;

   // corner kinds within a face
   localparam logic [1:0] KIND_TOP_LEFT     = 2'd0;
   localparam logic [1:0] KIND_TOP_RIGHT    = 2'd1;
   localparam logic [1:0] KIND_BOTTOM_RIGHT = 2'd2;
   localparam logic [1:0] KIND_BOTTOM_LEFT  = 2'd3;

   // which neighbour cell of a face corner is looked up
   typedef enum logic [1:0] {
      CELL_NORMAL = 2'd0,
      CELL_SIDE_R = 2'd1,
      CELL_SIDE_U = 2'd2,
      CELL_DIAG   = 2'd3
   } cell_sel_type;

   // request payload, last field in the low bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [MAP_W-1:0]   neighbour_empty;
      logic [BTYPE_W-1:0] block_type;
      logic [COORD_W-1:0] voxel_z;
      logic [COORD_W-1:0] voxel_y;
      logic [COORD_W-1:0] voxel_x;
   } req_item_type;

   // response payload, last field in the low bits
   typedef struct packed {
      logic [1:0]         pad;
      logic [INDEX_W-1:0] vertex_index;
      logic [1:0]         occlusion;
      logic [2:0]         face_dir;
      logic [BTYPE_W-1:0] face_block_type;
      logic [3:0]         tex_v_eighths;
      logic [1:0]         tex_u_thirds;
      logic [VERT_W-1:0]  vertex_z;
      logic [VERT_W-1:0]  vertex_y;
      logic [VERT_W-1:0]  vertex_x;
   } vertex_type;

   // corner offset and kind of one emitted vertex
   typedef struct packed {
      logic       ofs_x;
      logic       ofs_y;
      logic       ofs_z;
      logic [1:0] kind;
   } corner_type;

   // corner of the k-th vertex emitted for a face
   function automatic corner_type vertex_corner(input logic [2:0] face, input logic [1:0] k);
      corner_type c;
      case ({face, k})
         {FACE_TOP, 2'd0}:    c = '{1'b0, 1'b1, 1'b0, KIND_BOTTOM_LEFT};
         {FACE_TOP, 2'd1}:    c = '{1'b0, 1'b1, 1'b1, KIND_TOP_LEFT};
         {FACE_TOP, 2'd2}:    c = '{1'b1, 1'b1, 1'b1, KIND_TOP_RIGHT};
         {FACE_TOP, 2'd3}:    c = '{1'b1, 1'b1, 1'b0, KIND_BOTTOM_RIGHT};
         {FACE_BOTTOM, 2'd0}: c = '{1'b0, 1'b0, 1'b1, KIND_TOP_LEFT};
         {FACE_BOTTOM, 2'd1}: c = '{1'b0, 1'b0, 1'b0, KIND_BOTTOM_LEFT};
         {FACE_BOTTOM, 2'd2}: c = '{1'b1, 1'b0, 1'b0, KIND_BOTTOM_RIGHT};
         {FACE_BOTTOM, 2'd3}: c = '{1'b1, 1'b0, 1'b1, KIND_TOP_RIGHT};
         {FACE_LEFT, 2'd0}:   c = '{1'b0, 1'b0, 1'b1, KIND_BOTTOM_LEFT};
         {FACE_LEFT, 2'd1}:   c = '{1'b0, 1'b1, 1'b1, KIND_TOP_LEFT};
         {FACE_LEFT, 2'd2}:   c = '{1'b0, 1'b1, 1'b0, KIND_TOP_RIGHT};
         {FACE_LEFT, 2'd3}:   c = '{1'b0, 1'b0, 1'b0, KIND_BOTTOM_RIGHT};
         {FACE_RIGHT, 2'd0}:  c = '{1'b1, 1'b0, 1'b0, KIND_BOTTOM_RIGHT};
         {FACE_RIGHT, 2'd1}:  c = '{1'b1, 1'b1, 1'b0, KIND_TOP_RIGHT};
         {FACE_RIGHT, 2'd2}:  c = '{1'b1, 1'b1, 1'b1, KIND_TOP_LEFT};
         {FACE_RIGHT, 2'd3}:  c = '{1'b1, 1'b0, 1'b1, KIND_BOTTOM_LEFT};
         {FACE_FRONT, 2'd0}:  c = '{1'b0, 1'b0, 1'b0, KIND_BOTTOM_LEFT};
         {FACE_FRONT, 2'd1}:  c = '{1'b0, 1'b1, 1'b0, KIND_TOP_LEFT};
         {FACE_FRONT, 2'd2}:  c = '{1'b1, 1'b1, 1'b0, KIND_TOP_RIGHT};
         {FACE_FRONT, 2'd3}:  c = '{1'b1, 1'b0, 1'b0, KIND_BOTTOM_RIGHT};
         {FACE_BACK, 2'd0}:   c = '{1'b1, 1'b0, 1'b1, KIND_BOTTOM_RIGHT};
         {FACE_BACK, 2'd1}:   c = '{1'b1, 1'b1, 1'b1, KIND_TOP_RIGHT};
         {FACE_BACK, 2'd2}:   c = '{1'b0, 1'b1, 1'b1, KIND_TOP_LEFT};
         {FACE_BACK, 2'd3}:   c = '{1'b0, 1'b0, 1'b1, KIND_BOTTOM_LEFT};
         default:             c = '{1'b0, 1'b0, 1'b0, KIND_TOP_LEFT};
      endcase
      return c;
   endfunction

   // bit of the 3x3x3 empty map for a cell next to a face corner
   function automatic logic [4:0] cell_index(input logic [2:0] face, input logic [1:0] kind,
                                             input cell_sel_type sel);
      int nx, ny, nz, rx, ry, rz, ux, uy, uz;
      int sr, su, dx, dy, dz, idx;
      nx = 0; ny = 0; nz = 0;
      rx = 1; ry = 0; rz = 0;
      ux = 0; uy = 1; uz = 0;
      case (face)
         FACE_TOP: begin
            ny = 1; uy = 0; uz = 1;
         end
         FACE_BOTTOM: begin
            ny = -1; uy = 0; uz = 1;
         end
         FACE_LEFT: begin
            nx = -1; rx = 0; rz = -1;
         end
         FACE_RIGHT: begin
            nx = 1; rx = 0; rz = -1;
         end
         FACE_FRONT: begin
            nz = -1;
         end
         FACE_BACK: begin
            nz = 1;
         end
         default: begin
            ny = 1; uy = 0; uz = 1;
         end
      endcase
      sr = (kind == KIND_TOP_LEFT || kind == KIND_BOTTOM_LEFT) ? -1 : 1;
      su = (kind == KIND_TOP_LEFT || kind == KIND_TOP_RIGHT) ? 1 : -1;
      if (sel == CELL_NORMAL || sel == CELL_SIDE_U) begin
         sr = 0;
      end
      if (sel == CELL_NORMAL || sel == CELL_SIDE_R) begin
         su = 0;
      end
      dx = nx + sr * rx + su * ux;
      dy = ny + sr * ry + su * uy;
      dz = nz + sr * rz + su * uz;
      idx = (dx + 1) * 9 + (dy + 1) * 3 + (dz + 1);
      return 5'(idx);
   endfunction

endpackage

`default_nettype wire

// ===== design/voxel_face_mesher_ao.sv =====
// voxel_face_mesher_ao: per-voxel face culling and vertex emission with ambient occlusion
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------------
//  req_*    | in  | voxel x/y/z, block type, neighbour empty map; tuser chunk start
//  rsp_*    | out | one vertex per transfer; tlast on the voxel's final vertex
//
// a solid voxel emits 4 vertices per open face (0 to 24), one vertex per cycle unless
// rsp_tready stalls the output register, set by the single vertex generator feeding
// the output register; a voxel with no open face (or block type 0) is absorbed with no response.
// the next request is taken in the cycle the current voxel's last vertex is emitted.
// reset is synchronous, active high, and clears valids and the vertex counter.
// a stalled rsp_tready holds the output register and the voxel in flight.
`default_nettype none

module voxel_face_mesher_ao #(
   parameter int ChunkEdge = vfm_pkg::CHUNK_EDGE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata from bit 0: voxel_x[4], voxel_y[4], voxel_z[4], block_type[3],
   // neighbour_empty[27], zero pad[6]
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [vfm_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: chunk_start
   input  wire logic                          req_tuser,
   // rsp_tdata from bit 0: vertex_x[5], vertex_y[5], vertex_z[5], tex_u_thirds[2],
   // tex_v_eighths[4], face_block_type[3], face_dir[3], occlusion[2],
   // vertex_index[17], zero pad[2]
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [vfm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tlast: last_vertex
   output logic                               rsp_tlast
);
   import vfm_pkg::*;

   localparam int ClampMax = (ChunkEdge > 16) ? 15 : ChunkEdge - 1;

   // voxel in flight
   logic                 wk_valid_ff, wk_valid_in;
   logic [COORD_W-1:0]   wk_x_ff, wk_x_in;
   logic [COORD_W-1:0]   wk_y_ff, wk_y_in;
   logic [COORD_W-1:0]   wk_z_ff, wk_z_in;
   logic [BTYPE_W-1:0]   wk_bt_ff, wk_bt_in;
   logic [MAP_W-1:0]     wk_map_ff, wk_map_in;
   logic [FACES-1:0]     wk_mask_ff, wk_mask_in;
   logic [1:0]           wk_corner_ff, wk_corner_in;
   logic [INDEX_W-1:0]   count_ff, count_in;
   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   vertex_type           rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   req_item_type         req_item;
   logic                 accept, emit, done, vertex_last;
   logic [FACES-1:0]     new_mask, face_hot, mask_after;
   logic [2:0]           face;
   corner_type           corner;
   logic [1:0]           ao;
   logic [COORD_W-1:0]   cx, cy, cz;
   vertex_type           vert;

   assign req_item = req_item_type'(req_tdata);

   // clamp incoming coordinates to the chunk
   always_comb begin
      cx = req_item.voxel_x;
      cy = req_item.voxel_y;
      cz = req_item.voxel_z;
      if ({3'b000, req_item.voxel_x} >= 7'(ChunkEdge)) begin
         cx = COORD_W'(ClampMax);
      end
      if ({3'b000, req_item.voxel_y} >= 7'(ChunkEdge)) begin
         cy = COORD_W'(ClampMax);
      end
      if ({3'b000, req_item.voxel_z} >= 7'(ChunkEdge)) begin
         cz = COORD_W'(ClampMax);
      end
   end

   // open faces of the incoming voxel
   always_comb begin
      for (int f = 0; f < FACES; f++) begin
         new_mask[f] = (req_item.block_type != '0) &&
                       req_item.neighbour_empty[cell_index(3'(f), KIND_TOP_LEFT, CELL_NORMAL)];
      end
   end

   // lowest remaining face
   always_comb begin
      face = FACE_TOP;
      face_hot = '0;
      for (int f = FACES - 1; f >= 0; f--) begin
         if (wk_mask_ff[f]) begin
            face = 3'(f);
            face_hot = FACES'(1) << f;
         end
      end
      mask_after = (wk_corner_ff == 2'd3) ? (wk_mask_ff & ~face_hot) : wk_mask_ff;
      vertex_last = (wk_corner_ff == 2'd3) && (mask_after == '0);
   end

   // vertex generation
   always_comb begin
      corner = vertex_corner(face, wk_corner_ff);
      ao = 2'({1'b0, wk_map_ff[cell_index(face, corner.kind, CELL_SIDE_R)]}
            + {1'b0, wk_map_ff[cell_index(face, corner.kind, CELL_SIDE_U)]}
            + {1'b0, wk_map_ff[cell_index(face, corner.kind, CELL_DIAG)]});
      vert = '0;
      vert.vertex_x = {1'b0, wk_x_ff} + VERT_W'(corner.ofs_x);
      vert.vertex_y = {1'b0, wk_y_ff} + VERT_W'(corner.ofs_y);
      vert.vertex_z = {1'b0, wk_z_ff} + VERT_W'(corner.ofs_z);
      case (face)
         FACE_TOP:    vert.tex_u_thirds = 2'd2;
         FACE_BOTTOM: vert.tex_u_thirds = 2'd0;
         default:     vert.tex_u_thirds = 2'd1;
      endcase
      if (corner.kind == KIND_TOP_LEFT || corner.kind == KIND_BOTTOM_LEFT) begin
         vert.tex_u_thirds = vert.tex_u_thirds + 2'd1;
      end
      vert.tex_v_eighths = {1'b0, wk_bt_ff} +
         4'((corner.kind == KIND_BOTTOM_RIGHT || corner.kind == KIND_BOTTOM_LEFT) ? 1 : 0);
      vert.face_block_type = wk_bt_ff;
      vert.face_dir = face;
      vert.occlusion = ao;
      vert.vertex_index = count_ff;
   end

   // handshake
   assign emit = wk_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign done = emit && vertex_last;
   assign req_tready = !wk_valid_ff || done;
   assign accept = req_tvalid && req_tready;

   // next state of the voxel in flight and the counter
   always_comb begin
      wk_valid_in = wk_valid_ff;
      wk_x_in = wk_x_ff;
      wk_y_in = wk_y_ff;
      wk_z_in = wk_z_ff;
      wk_bt_in = wk_bt_ff;
      wk_map_in = wk_map_ff;
      wk_mask_in = wk_mask_ff;
      wk_corner_in = wk_corner_ff;
      count_in = count_ff;
      if (emit) begin
         count_in = count_ff + INDEX_W'(1);
         wk_corner_in = wk_corner_ff + 2'd1;
         wk_mask_in = mask_after;
         if (vertex_last) begin
            wk_valid_in = 1'b0;
         end
      end
      if (accept) begin
         wk_valid_in = |new_mask;
         wk_x_in = cx;
         wk_y_in = cy;
         wk_z_in = cz;
         wk_bt_in = req_item.block_type;
         wk_map_in = req_item.neighbour_empty;
         wk_mask_in = new_mask;
         wk_corner_in = 2'd0;
         if (req_tuser) begin
            count_in = '0;
         end
      end
   end

   // output register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = vert;
         rsp_last_in = vertex_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wk_valid_ff <= wk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wk_x_ff <= wk_x_in;
      wk_y_ff <= wk_y_in;
      wk_z_ff <= wk_z_in;
      wk_bt_ff <= wk_bt_in;
      wk_map_ff <= wk_map_in;
      wk_mask_ff <= wk_mask_in;
      wk_corner_ff <= wk_corner_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tlast = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/vfm_checker.sv =====
// vfm_checker: port-level assertions for the voxel face mesher, bound to the top level
`default_nettype none

module vfm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [vfm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tlast
);
   import vfm_pkg::*;

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // stalled response payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response payload changed while stalled");

   // a voxel still emitting blocks new requests while the output is stalled
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && !rsp_tready |-> !req_tready)
      else $error("request taken while voxel vertices pending");

   // consecutive vertices of one voxel get consecutive indices
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) ##1 (rsp_tvalid && rsp_tready) |->
      rsp_tdata[45:29] == 17'($past(rsp_tdata[45:29]) + 17'd1))
      else $error("vertex index not consecutive within a voxel");

endmodule

bind voxel_face_mesher_ao vfm_checker u_vfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
